// ===== rtl/core/dhh_pkg.sv =====
// Shared types and constants for the differential heading hold block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package dhh_pkg;

	localparam int PI_Q       = 12868;
	localparam int TWO_PI_Q   = 25736;
	localparam int DIFF_LIMIT = 50;
	localparam int DIFF_GAIN  = 100;
	localparam int BASE_SPEED = 200;

	localparam int DIST_W   = 32;
	localparam int DELTA_W  = DIST_W + 1;
	localparam int TRACK_W  = 24;
	localparam int HEAD_W   = 15;
	localparam int ERR_W    = 16;
	localparam int SPEED_W  = 8;
	localparam int LO_W     = 17;
	localparam int PLO_W    = LO_W + TRACK_W;
	localparam int FULL_W   = DELTA_W + TRACK_W;
	localparam int FRAC_W   = 16;
	localparam int ANG_W    = FULL_W - FRAC_W;
	localparam int QUO_W    = HEAD_W - 1;

	localparam logic [TRACK_W-1:0] TRACK_RESET = 24'd65536;

	// steering term: floor(|err| * 100 / PI_Q) by reciprocal, exact below saturation
	localparam int DIFF_SHIFT = 34;
	localparam int DIFF_MUL_W = 27;
	localparam int DIFF_MAG_W = 6;
	localparam logic [63:0] DIFF_RECIP =
		((64'd1 << DIFF_SHIFT) + 64'(PI_Q) - 64'd1) / 64'(PI_Q);
	localparam logic [DIFF_MUL_W-1:0] DIFF_MUL = DIFF_MUL_W'(DIFF_RECIP * 64'(DIFF_GAIN));
	localparam int DIFF_SAT_ERR = (PI_Q * DIFF_LIMIT + DIFF_GAIN - 1) / DIFF_GAIN;

	typedef logic [1:0] mul_sel_t;

	localparam mul_sel_t MUL_LO  = 2'd0;
	localparam mul_sel_t MUL_HI  = 2'd1;
	localparam mul_sel_t MUL_AVG = 2'd2;
	localparam mul_sel_t MUL_DIF = 2'd3;

	typedef struct packed {
		logic     capture;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     load_plo;
		logic     load_head;
		logic     push;
		logic     load_avg;
		logic     load_out;
	} dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/dhh_mul.sv =====
// Registered signed multiplier shared by all product steps of a word.
// Stand-alone; no package dependencies.
`default_nettype none

module dhh_mul #(
	parameter int A_W = 18,
	parameter int B_W = 28
) (
	input  wire                        clk,
	input  wire                        en,
	input  wire  signed [A_W-1:0]      a,
	input  wire  signed [B_W-1:0]      b,
	output logic signed [A_W+B_W-1:0]  p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/dhh_ctrl.sv =====
// Sequencing controller: handshakes and the per-word step sequence.
// Depends on dhh_pkg for the datapath command struct and multiplier selects.
`default_nettype none

module dhh_ctrl
	import dhh_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	input  wire     in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  wire     out_stall,
	output dp_cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MLO  = 4'd1;
	localparam logic [3:0] S_MHI  = 4'd2;
	localparam logic [3:0] S_HEAD = 4'd3;
	localparam logic [3:0] S_PUSH = 4'd4;
	localparam logic [3:0] S_MAVG = 4'd5;
	localparam logic [3:0] S_AVGE = 4'd6;
	localparam logic [3:0] S_MDIF = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_MLO;
				end
			end
			S_MLO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_LO;
				state_d     = S_MHI;
			end
			S_MHI: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_HI;
				cmd.load_plo = 1'b1;
				state_d      = S_HEAD;
			end
			S_HEAD: begin
				cmd.load_head = 1'b1;
				state_d       = S_PUSH;
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_MAVG;
			end
			S_MAVG: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AVG;
				state_d     = S_AVGE;
			end
			S_AVGE: begin
				cmd.load_avg = 1'b1;
				state_d      = S_MDIF;
			end
			S_MDIF: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DIF;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an untaken word");
	a_capture_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_MLO))
		else $error("accepted word did not start the sequence");
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("output valid raised outside the final step");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (!cmd.mul_en && !cmd.push && !cmd.load_avg))
		else $error("datapath commanded while idle");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/dhh_dp.sv =====
// Datapath: heading product, wrap, history window, average and steering term.
// Depends on dhh_pkg and dhh_mul; driven by commands from dhh_ctrl.
`default_nettype none

module dhh_dp
	import dhh_pkg::*;
#(
	parameter int WINDOW = 5
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  dp_cmd_t                   cmd,
	input  wire                       cfg_we,
	input  wire         [TRACK_W-1:0] cfg_wdata,
	input  wire  signed [DIST_W-1:0]  left_distance,
	input  wire  signed [DIST_W-1:0]  right_distance,
	input  wire  signed [HEAD_W-1:0]  target_heading,
	output logic        [SPEED_W-1:0] left_speed,
	output logic        [SPEED_W-1:0] right_speed,
	output logic signed [ERR_W-1:0]   heading_error,
	output logic signed [HEAD_W-1:0]  average_heading
);

	localparam int SLOT_W  = $clog2(WINDOW);
	localparam int SUM_W   = HEAD_W + $clog2(WINDOW);
	localparam int MAG_W   = SUM_W - 1;
	localparam int AVG_K   = MAG_W + $clog2(WINDOW);
	localparam int AVG_M_W = MAG_W + 2;
	localparam logic [AVG_M_W-1:0] AVG_M =
		AVG_M_W'(((64'd1 << AVG_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
	localparam int A_W = (MAG_W + 1 > LO_W + 1) ? MAG_W + 1 : LO_W + 1;
	localparam int B_W = (AVG_M_W + 1 > DIFF_MUL_W + 1) ? AVG_M_W + 1 : DIFF_MUL_W + 1;
	localparam int P_W = A_W + B_W;

	logic        [TRACK_W-1:0] inv_track_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic signed [HEAD_W-1:0]  target_q;
	logic        [PLO_W-1:0]   plo_q;
	logic signed [ANG_W-1:0]   ang_q;
	logic signed [HEAD_W-1:0]  hist_q [WINDOW];
	logic signed [SUM_W-1:0]   sum_q;
	logic        [SLOT_W-1:0]  slot_q;
	logic signed [HEAD_W-1:0]  avg_q;
	logic signed [ERR_W-1:0]   err_q;
	logic        [SPEED_W-1:0] left_q;
	logic        [SPEED_W-1:0] right_q;
	logic signed [ERR_W-1:0]   err_out_q;
	logic signed [HEAD_W-1:0]  avg_out_q;

	logic signed [A_W-1:0]     mul_a;
	logic signed [B_W-1:0]     mul_b;
	logic signed [P_W-1:0]     prod_q;
	logic signed [FULL_W-1:0]  p_full;
	logic signed [ANG_W-1:0]   ang_wrap;
	logic signed [HEAD_W-1:0]  head;
	logic signed [SUM_W-1:0]   sum_d;
	logic        [MAG_W-1:0]   sum_mag;
	logic        [QUO_W-1:0]   quo;
	logic signed [HEAD_W-1:0]  avg_d;
	logic        [ERR_W-2:0]   err_mag;
	logic        [DIFF_MAG_W-1:0] diff_mag;

	assign sum_mag = sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
	assign err_mag = err_q[ERR_W-1] ? (ERR_W-1)'(-err_q) : (ERR_W-1)'(err_q);

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_LO: begin
				mul_a = A_W'({1'b0, delta_q[LO_W-1:0]});
				mul_b = B_W'(inv_track_q);
			end
			MUL_HI: begin
				mul_a = A_W'(signed'(delta_q[DELTA_W-1:LO_W]));
				mul_b = B_W'(inv_track_q);
			end
			MUL_AVG: begin
				mul_a = A_W'(sum_mag);
				mul_b = B_W'(AVG_M);
			end
			MUL_DIF: begin
				mul_a = A_W'(err_mag);
				mul_b = B_W'(DIFF_MUL);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	dhh_mul #(
		.A_W (A_W),
		.B_W (B_W)
	) u_mul (
		.clk (clk),
		.en  (cmd.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	// rebuild the full product from the two halves, floor by the fraction
	assign p_full = (FULL_W'(prod_q) <<< LO_W) + FULL_W'(plo_q);

	always_comb begin
		if (ang_q > ANG_W'(PI_Q)) begin
			ang_wrap = ang_q - ANG_W'(TWO_PI_Q);
		end else if (ang_q <= -ANG_W'(PI_Q)) begin
			ang_wrap = ang_q + ANG_W'(TWO_PI_Q);
		end else begin
			ang_wrap = ang_q;
		end
		if (ang_wrap > ANG_W'(PI_Q)) begin
			head = HEAD_W'(PI_Q);
		end else if (ang_wrap < -ANG_W'(PI_Q - 1)) begin
			head = -HEAD_W'(PI_Q - 1);
		end else begin
			head = HEAD_W'(ang_wrap);
		end
	end

	assign sum_d = sum_q - SUM_W'(hist_q[slot_q]) + SUM_W'(head);

	assign quo   = prod_q[AVG_K +: QUO_W];
	assign avg_d = sum_q[SUM_W-1] ? -signed'({1'b0, quo}) : signed'({1'b0, quo});

	assign diff_mag = (err_mag >= (ERR_W-1)'(DIFF_SAT_ERR)) ? DIFF_MAG_W'(DIFF_LIMIT)
		: prod_q[DIFF_SHIFT +: DIFF_MAG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_track_q <= TRACK_RESET;
			sum_q       <= '0;
			slot_q      <= '0;
			for (int i = 0; i < WINDOW; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				inv_track_q <= cfg_wdata;
			end
			if (cmd.push) begin
				hist_q[slot_q] <= head;
				sum_q          <= sum_d;
				slot_q         <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			delta_q  <= DELTA_W'(right_distance) - DELTA_W'(left_distance);
			target_q <= target_heading;
		end
		if (cmd.load_plo) begin
			plo_q <= PLO_W'(prod_q);
		end
		if (cmd.load_head) begin
			ang_q <= p_full[FULL_W-1:FRAC_W];
		end
		if (cmd.load_avg) begin
			avg_q <= avg_d;
			err_q <= ERR_W'(target_q) - ERR_W'(avg_d);
		end
		if (cmd.load_out) begin
			avg_out_q <= avg_q;
			err_out_q <= err_q;
			if (err_q[ERR_W-1]) begin
				left_q  <= SPEED_W'(BASE_SPEED) + SPEED_W'(diff_mag);
				right_q <= SPEED_W'(BASE_SPEED) - SPEED_W'(diff_mag);
			end else begin
				left_q  <= SPEED_W'(BASE_SPEED) - SPEED_W'(diff_mag);
				right_q <= SPEED_W'(BASE_SPEED) + SPEED_W'(diff_mag);
			end
		end
	end

	assign left_speed      = left_q;
	assign right_speed     = right_q;
	assign heading_error   = err_out_q;
	assign average_heading = avg_out_q;

`ifndef SYNTHESIS
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(WINDOW - 1))
		else $error("history slot beyond window");
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_q <= WINDOW * PI_Q) && (sum_q >= -(WINDOW * (PI_Q - 1))))
		else $error("history sum outside window bounds");
	a_speed_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> ((9'(left_q) + 9'(right_q)) == 9'(2 * BASE_SPEED)))
		else $error("wheel speeds not symmetric about base speed");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/differential_heading_hold.sv =====
// Top level of the differential heading hold steering block.
// Depends on dhh_pkg, dhh_ctrl, dhh_dp and dhh_mul.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   left_distance, right_distance, target_heading
//   out      source     out_valid / out_stall left_speed, right_speed, heading_error,
//                                             average_heading
//   cfg      sink       cfg_we                cfg_wdata (inv_track)
//
// A word passes through eight steps after acceptance, set by the one shared
// multiplier used four times in sequence (two track products, average, steering).
// The next word is accepted in the cycle after a result is loaded.
// Reset clears the heading history, sum and slot and sets inv_track to 65536.
// A stalled result is held in the output register; one further word is worked
// and waits in its final step until that register is taken.
`default_nettype none

module differential_heading_hold
	import dhh_pkg::*;
#(
	parameter int WINDOW = 5
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire  signed [DIST_W-1:0]  left_distance,
	input  wire  signed [DIST_W-1:0]  right_distance,
	input  wire  signed [HEAD_W-1:0]  target_heading,
	output logic                      out_valid,
	input  wire                       out_stall,
	output logic        [SPEED_W-1:0] left_speed,
	output logic        [SPEED_W-1:0] right_speed,
	output logic signed [ERR_W-1:0]   heading_error,
	output logic signed [HEAD_W-1:0]  average_heading,
	input  wire                       cfg_we,
	input  wire         [TRACK_W-1:0] cfg_wdata
);

	dp_cmd_t cmd;

	dhh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	dhh_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.left_distance   (left_distance),
		.right_distance  (right_distance),
		.target_heading  (target_heading),
		.left_speed      (left_speed),
		.right_speed     (right_speed),
		.heading_error   (heading_error),
		.average_heading (average_heading)
	);

endmodule

`default_nettype wire

// ===== dv/differential_heading_hold_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for differential_heading_hold: watches the word, result and register ports,
// predicts every drive command and compares it field by field. Depends on dhh_pkg.

module differential_heading_hold_checker
	import dhh_pkg::*;
#(
	parameter int WINDOW = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic signed [DIST_W-1:0]  left_distance,
	input  logic signed [DIST_W-1:0]  right_distance,
	input  logic signed [HEAD_W-1:0]  target_heading,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic        [SPEED_W-1:0] left_speed,
	input  logic        [SPEED_W-1:0] right_speed,
	input  logic signed [ERR_W-1:0]   heading_error,
	input  logic signed [HEAD_W-1:0]  average_heading,
	input  logic                      cfg_we,
	input  logic        [TRACK_W-1:0] cfg_wdata,
	output int                        fail_count,
	output int                        pending_words
);

	typedef struct {
		logic        [SPEED_W-1:0] left_speed;
		logic        [SPEED_W-1:0] right_speed;
		logic signed [ERR_W-1:0]   heading_error;
		logic signed [HEAD_W-1:0]  average_heading;
	} drive_cmd_t;

	drive_cmd_t         drive_queue[$];
	logic [TRACK_W-1:0] track;
	int                 heading_window[WINDOW];
	int                 window_sum;
	int                 window_slot;

	function automatic drive_cmd_t predict_drive(logic signed [DIST_W-1:0] l,
			logic signed [DIST_W-1:0] r, logic signed [HEAD_W-1:0] t);
		longint     ang;
		int         avg_h;
		int         err;
		int         diff;
		drive_cmd_t cmd;
		ang = ((longint'(r) - longint'(l)) * longint'(track)) >>> FRAC_W;
		// wrap once, then clamp whatever is still out of range
		if (ang > PI_Q)
			ang -= TWO_PI_Q;
		else if (ang <= -PI_Q)
			ang += TWO_PI_Q;
		if (ang > PI_Q)
			ang = PI_Q;
		if (ang < -(PI_Q - 1))
			ang = -(PI_Q - 1);
		if (window_slot >= WINDOW)
			window_slot = 0;
		window_sum = window_sum - heading_window[window_slot] + int'(ang);
		heading_window[window_slot] = int'(ang);
		window_slot = (window_slot + 1 >= WINDOW) ? 0 : window_slot + 1;
		avg_h = window_sum / WINDOW;
		err = int'(t) - avg_h;
		diff = (err * DIFF_GAIN) / PI_Q;
		if (diff < -DIFF_LIMIT)
			diff = -DIFF_LIMIT;
		if (diff > DIFF_LIMIT)
			diff = DIFF_LIMIT;
		cmd.left_speed = SPEED_W'(BASE_SPEED - diff);
		cmd.right_speed = SPEED_W'(BASE_SPEED + diff);
		cmd.heading_error = ERR_W'(err);
		cmd.average_heading = HEAD_W'(avg_h);
		return cmd;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_cmd_t want;
		int         errs;
		errs = 0;
		if (!arst_n) begin
			track = TRACK_RESET;
			heading_window = '{default: 0};
			window_sum = 0;
			window_slot = 0;
			drive_queue.delete();
			fail_count <= 0;
			pending_words <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (drive_queue.size() == 0) begin
					$error("unexpected result word: left_speed %0d right_speed %0d",
						left_speed, right_speed);
					errs++;
				end else begin
					want = drive_queue.pop_front();
					if (left_speed !== want.left_speed) begin
						$error("left_speed: expected %0d, got %0d", want.left_speed, left_speed);
						errs++;
					end
					if (right_speed !== want.right_speed) begin
						$error("right_speed: expected %0d, got %0d", want.right_speed,
							right_speed);
						errs++;
					end
					if (heading_error !== want.heading_error) begin
						$error("heading_error: expected %0d, got %0d", want.heading_error,
							heading_error);
						errs++;
					end
					if (average_heading !== want.average_heading) begin
						$error("average_heading: expected %0d, got %0d", want.average_heading,
							average_heading);
						errs++;
					end
				end
			end
			if (in_valid && !in_stall)
				drive_queue.push_back(predict_drive(left_distance, right_distance,
					target_heading));
			if (cfg_we)
				track = cfg_wdata;
			fail_count <= fail_count + errs;
			pending_words <= drive_queue.size();
		end
	end

endmodule

// ===== dv/differential_heading_hold_tb.sv =====
`timescale 1ns / 1ps
// Top of the differential_heading_hold testbench: clock, reset, stimulus and verdict.
// Depends on dhh_pkg, the block and differential_heading_hold_checker.

module differential_heading_hold_tb;
	import dhh_pkg::*;

	localparam int     WINDOW         = 5;
	localparam int     PHASES         = 12;
	localparam int     PHASE_WORDS    = 140;
	localparam int     SETTLE_CYCLES  = 12;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam longint DIST_MIN       = -(longint'(1) <<< (DIST_W - 1));
	localparam longint DIST_MAX       = (longint'(1) <<< (DIST_W - 1)) - 1;

	logic                      clk             = 1'b0;
	logic                      arst_n          = 1'b0;
	logic                      in_valid        = 1'b0;
	logic                      in_stall;
	logic signed [DIST_W-1:0]  left_distance   = '0;
	logic signed [DIST_W-1:0]  right_distance  = '0;
	logic signed [HEAD_W-1:0]  target_heading  = '0;
	logic                      out_valid;
	logic                      out_stall       = 1'b0;
	logic        [SPEED_W-1:0] left_speed;
	logic        [SPEED_W-1:0] right_speed;
	logic signed [ERR_W-1:0]   heading_error;
	logic signed [HEAD_W-1:0]  average_heading;
	logic                      cfg_we          = 1'b0;
	logic        [TRACK_W-1:0] cfg_wdata       = '0;

	int                 fail_count;
	int                 pending_words;
	int                 quiet_cycles       = 0;
	int                 sender_idle_pct    = 0;
	int                 receiver_stall_pct = 0;
	logic [TRACK_W-1:0] track_setting      = TRACK_RESET;

	differential_heading_hold #(
		.WINDOW(WINDOW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.left_distance(left_distance),
		.right_distance(right_distance),
		.target_heading(target_heading),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_speed(left_speed),
		.right_speed(right_speed),
		.heading_error(heading_error),
		.average_heading(average_heading),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	differential_heading_hold_checker #(
		.WINDOW(WINDOW)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.left_distance(left_distance),
		.right_distance(right_distance),
		.target_heading(target_heading),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_speed(left_speed),
		.right_speed(right_speed),
		.heading_error(heading_error),
		.average_heading(average_heading),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.pending_words(pending_words)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic send_word(input logic signed [DIST_W-1:0] l,
			input logic signed [DIST_W-1:0] r, input logic signed [HEAD_W-1:0] t);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_distance <= l;
		right_distance <= r;
		target_heading <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_random_word();
		longint              h;
		longint              delta;
		longint              lo;
		longint              hi;
		longint              l_full;
		longint unsigned     span;
		logic signed [HEAD_W-1:0] t;
		int                  pick;
		pick = $urandom_range(99);
		if ($urandom_range(99) < 85)
			t = HEAD_W'(int'($urandom_range(2 * PI_Q)) - PI_Q);
		else
			t = HEAD_W'($urandom);
		if (pick < 10 || track_setting == '0) begin
			send_word(DIST_W'($urandom), DIST_W'($urandom), t);
		end else begin
			// aim the heading in range mostly, sometimes past one or two wraps
			if (pick < 60)
				h = longint'($urandom_range(2 * PI_Q)) - PI_Q;
			else
				h = longint'($urandom_range(80000)) - 40000;
			delta = ((h <<< FRAC_W) / longint'(track_setting)) + longint'($urandom_range(2)) - 1;
			lo = (delta < 0) ? DIST_MIN - delta : DIST_MIN;
			hi = (delta > 0) ? DIST_MAX - delta : DIST_MAX;
			span = longint'(hi - lo) + 1;
			l_full = lo + longint'({$urandom, $urandom} % span);
			send_word(DIST_W'(l_full), DIST_W'(l_full + delta), t);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_words != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_track(input logic [TRACK_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		track_setting = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset track: the heading is the distance difference itself
		send_word(0, 0, 0);
		send_word(0, PI_Q, PI_Q);
		send_word(0, PI_Q + 1, -PI_Q);
		send_word(PI_Q, 0, 16383);
		send_word(PI_Q - 1, 0, -16384);
		send_word(0, PI_Q + TWO_PI_Q + 1, 16383);
		send_word(PI_Q + TWO_PI_Q + 1, 0, -16384);
		send_word(32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_word(32'h7FFF_FFFF, 32'h8000_0000, -PI_Q);
		send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, PI_Q);
		send_word(32'h8000_0000, 32'h8000_0000, -PI_Q);
		send_word(32'h5555_5555, 32'hAAAA_AAAA, 15'h2AAA);
		send_word(32'hAAAA_AAAA, 32'h5555_5555, 15'h5555);
		send_word(0, -1, 6434);
		send_word(-1, 0, 6563);
		send_word(100, 50, -6434);
		send_word(50, 100, -6563);
		send_word(0, 0, 0);
		send_word(0, 0, 0);
		send_word(0, 0, 0);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_track(24'd1);
				1: write_track('1);
				2: write_track('0);
				3: write_track(TRACK_RESET);
				default: write_track(phase[0] ? TRACK_W'($urandom_range(20000, 200000))
					: TRACK_W'($urandom_range(1, 24'hFF_FFFF)));
			endcase
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 66;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 66;
				end
				default: begin
					sender_idle_pct = 35;
					receiver_stall_pct = 35;
				end
			endcase
			repeat (PHASE_WORDS) send_random_word();
			drain();
		end

		if (fail_count == 0 && pending_words == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/dhh_pkg.sv
rtl/core/dhh_mul.sv
rtl/core/dhh_ctrl.sv
rtl/core/dhh_dp.sv
rtl/core/differential_heading_hold.sv
dv/differential_heading_hold_checker.sv
dv/differential_heading_hold_tb.sv
